[hw/rtl/b64d_pkg.sv]
// shared types, constants and the character classifier of the base64 stream decoder
`default_nettype none

package b64d_pkg;

   // largest byte count a string may decode to
   localparam logic [15:0] MAX_OUTPUT_BYTES = 16'hFFFF;

   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUT_CAPACITY = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNT_ONLY   = 1'b1;

   localparam logic [15:0] OUT_CAPACITY_RESET = 16'hFFFF;

   localparam logic [1:0] PAD_NONE = 2'd0;
   localparam logic [1:0] PAD_ONE  = 2'd1;
   localparam logic [1:0] PAD_DONE = 2'd2;

   typedef enum logic [2:0] {
      CHR_DATA,
      CHR_SPACE,
      CHR_PAD,
      CHR_BAD,
      CHR_END
   } chr_kind_type;

   typedef struct packed {
      chr_kind_type kind;
      logic [5:0]   sextet;
   } chr_class_type;

   function automatic chr_class_type classify(input logic [7:0] c);
      chr_class_type r;
      r.kind   = CHR_BAD;
      r.sextet = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r.kind   = CHR_DATA;
         r.sextet = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r.kind   = CHR_DATA;
         r.sextet = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r.kind   = CHR_DATA;
         r.sextet = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         r.kind   = CHR_DATA;
         r.sextet = 6'd62;
      end else if (c == 8'h2F) begin
         r.kind   = CHR_DATA;
         r.sextet = 6'd63;
      end else if (c == 8'h00) begin
         r.kind = CHR_END;
      end else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) begin
         r.kind = CHR_SPACE;
      end else if (c == 8'h3D) begin
         r.kind = CHR_PAD;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/base64_stream_decoder_top.sv]
// Decodes a base64 character stream into bytes, one character per cycle, with
// a status word at the end of each string. Every accepted character is classified and
// folded into the group state in the cycle it is taken; a data word or a final status
// word, if the character causes one, sits in the output register the next cycle. The
// block takes one character per cycle, set by the single output register: req_ready is
// low only while that register holds a word that rsp_ready has not yet taken.
// Configuration writes take effect from the next character.
`default_nettype none

module base64_stream_decoder_top
   import b64d_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire logic [7:0]                 req_char_code,

   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic [7:0]                 rsp_data_byte,
   output      logic                       rsp_is_final,
   output      logic                       rsp_status_ok,
   output      logic [15:0]                rsp_byte_count,

   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [15:0] out_capacity_ff;
   logic        count_only_ff;

   logic [1:0]  quarter_ff, quarter_in;
   logic [1:0]  pad_ff, pad_in;
   logic [7:0]  residual_ff, residual_in;
   logic [15:0] count_ff, count_in;
   logic        discard_ff, discard_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_final_ff, rsp_final_in;
   logic        rsp_ok_ff, rsp_ok_in;
   logic [15:0] rsp_count_ff, rsp_count_in;

   logic          accept;
   logic          emit;
   chr_class_type cls;
   logic [16:0]   need;
   logic          cap_fail;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign cls       = classify(req_char_code);

   // decode mode checks count, or count plus one before a byte slot that starts mid-group
   assign need = {1'b0, count_ff} +
                 17'((quarter_ff == 2'd1 || quarter_ff == 2'd2) ? 1 : 0);

   always_comb begin
      if (count_only_ff) begin
         cap_fail = (quarter_ff != 2'd0) && (count_ff >= MAX_OUTPUT_BYTES);
      end else begin
         cap_fail = (need >= {1'b0, out_capacity_ff}) ||
                    (need >= {1'b0, MAX_OUTPUT_BYTES});
      end
   end

   always_comb begin
      logic do_final;
      logic final_ok;
      logic set_disc;
      logic do_clear;
      logic do_byte;
      logic [7:0] byte_val;

      do_final = 1'b0;
      final_ok = 1'b0;
      set_disc = 1'b0;
      do_clear = 1'b0;
      do_byte  = 1'b0;
      byte_val = 8'd0;

      quarter_in  = quarter_ff;
      pad_in      = pad_ff;
      residual_in = residual_ff;
      count_in    = count_ff;
      discard_in  = discard_ff;

      if (accept) begin
         priority if (discard_ff) begin
            do_clear = (cls.kind == CHR_END);
         end else if (cls.kind == CHR_SPACE) begin
            do_clear = 1'b0;
         end else if (pad_ff == PAD_ONE) begin
            if (cls.kind == CHR_PAD) begin
               pad_in = PAD_DONE;
            end else begin
               do_final = 1'b1;
               set_disc = (cls.kind != CHR_END);
            end
         end else if (pad_ff != PAD_NONE) begin
            do_final = 1'b1;
            if (cls.kind != CHR_END) begin
               set_disc = 1'b1;
            end else begin
               // leftover bits after padding must be zero when really decoding
               final_ok = count_only_ff || (residual_ff == 8'd0);
            end
         end else if (cls.kind == CHR_END) begin
            do_final = 1'b1;
            final_ok = (quarter_ff == 2'd0);
         end else if (cls.kind == CHR_BAD) begin
            do_final = 1'b1;
            set_disc = 1'b1;
         end else if (cls.kind == CHR_PAD) begin
            priority if (quarter_ff == 2'd2) begin
               pad_in = PAD_ONE;
            end else if (quarter_ff == 2'd3) begin
               pad_in = PAD_DONE;
            end else begin
               do_final = 1'b1;
               set_disc = 1'b1;
            end
         end else if (cap_fail) begin
            do_final = 1'b1;
            set_disc = 1'b1;
         end else begin
            unique case (quarter_ff)
               2'd0: begin
                  residual_in = {cls.sextet, 2'b00};
                  quarter_in  = 2'd1;
               end
               2'd1: begin
                  do_byte     = 1'b1;
                  byte_val    = residual_ff | {6'd0, cls.sextet[5:4]};
                  residual_in = {cls.sextet[3:0], 4'd0};
                  quarter_in  = 2'd2;
               end
               2'd2: begin
                  do_byte     = 1'b1;
                  byte_val    = residual_ff | {4'd0, cls.sextet[5:2]};
                  residual_in = {cls.sextet[1:0], 6'd0};
                  quarter_in  = 2'd3;
               end
               default: begin
                  do_byte     = 1'b1;
                  byte_val    = residual_ff | {2'd0, cls.sextet};
                  residual_in = 8'd0;
                  quarter_in  = 2'd0;
               end
            endcase
         end
      end

      if (do_byte) begin
         count_in = count_ff + 16'd1;
      end

      if (do_final || do_clear) begin
         quarter_in  = 2'd0;
         pad_in      = PAD_NONE;
         residual_in = 8'd0;
         count_in    = 16'd0;
         discard_in  = set_disc;
      end

      emit         = do_final || do_byte;
      rsp_byte_in  = byte_val;
      rsp_final_in = do_final;
      rsp_ok_in    = do_final && final_ok;
      rsp_count_in = do_final ? count_ff : count_in;
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_capacity_ff <= OUT_CAPACITY_RESET;
         count_only_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OUT_CAPACITY: out_capacity_ff <= csr_wdata;
            CSR_COUNT_ONLY:   count_only_ff   <= csr_wdata[0];
            default:          count_only_ff   <= count_only_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quarter_ff   <= 2'd0;
         pad_ff       <= PAD_NONE;
         residual_ff  <= 8'd0;
         count_ff     <= 16'd0;
         discard_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         quarter_ff   <= quarter_in;
         pad_ff       <= pad_in;
         residual_ff  <= residual_in;
         count_ff     <= count_in;
         discard_ff   <= discard_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff  <= rsp_byte_in;
         rsp_final_ff <= rsp_final_in;
         rsp_ok_ff    <= rsp_ok_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_byte  = rsp_byte_ff;
   assign rsp_is_final   = rsp_final_ff;
   assign rsp_status_ok  = rsp_ok_ff;
   assign rsp_byte_count = rsp_count_ff;

   // discarding only follows a cleared string
   a_discard_clean : assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> (quarter_ff == 2'd0 && pad_ff == PAD_NONE && count_ff == 16'd0))
      else $error("discard state with live group state");

   // one pad is only legal after the second character of a group
   a_pad_one_phase : assert property (@(posedge clock) disable iff (reset)
      (pad_ff == PAD_ONE) |-> (quarter_ff == 2'd2))
      else $error("pending second pad outside group position 2");

   a_pad_done_phase : assert property (@(posedge clock) disable iff (reset)
      (pad_ff == PAD_DONE) |-> (quarter_ff == 2'd2 || quarter_ff == 2'd3))
      else $error("padding done in wrong group position");

   // a data word always counts itself
   a_data_counted : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_final_ff) |-> (rsp_count_ff != 16'd0 && !rsp_ok_ff))
      else $error("data word with zero count or status set");

   // a word held back by the sink is not overwritten
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !accept)
      else $error("word accepted while result register is stalled");

endmodule

`default_nettype wire

[verif/b64d_stream_checker.sv]
// checker for the base64 stream decoder: predicts every output word and compares it
module b64d_stream_checker
   import b64d_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic                       req_ready,
   input  wire logic [7:0]                 req_char_code,
   input  wire logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire logic [7:0]                 rsp_data_byte,
   input  wire logic                       rsp_is_final,
   input  wire logic                       rsp_status_ok,
   input  wire logic [15:0]                rsp_byte_count,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                              mismatch_count,
   output int                              words_pending
);

   typedef struct {
      logic [7:0]  data_byte;
      logic        is_final;
      logic        status_ok;
      logic [15:0] byte_count;
   } out_word_type;

   out_word_type expected_words[$];
   int errors = 0;

   // shadow registers
   logic [15:0] capacity;
   logic        count_mode;

   // shadow string state
   logic [1:0]  group_pos;
   logic [1:0]  pad_state;
   logic [7:0]  residue;
   logic [15:0] byte_total;
   logic        dropping;

   task automatic report(input string msg);
      errors++;
      if (errors <= 100) begin
         $display("MISMATCH at %0t: %s", $time, msg);
      end
   endtask

   function automatic chr_kind_type kind_of(input logic [7:0] c, output logic [5:0] value);
      value = 6'd0;
      if (c >= "A" && c <= "Z") begin
         value = 6'(c - "A");
         return CHR_DATA;
      end
      if (c >= "a" && c <= "z") begin
         value = 6'(c - "a" + 8'd26);
         return CHR_DATA;
      end
      if (c >= "0" && c <= "9") begin
         value = 6'(c - "0" + 8'd52);
         return CHR_DATA;
      end
      if (c == "+") begin
         value = 6'd62;
         return CHR_DATA;
      end
      if (c == "/") begin
         value = 6'd63;
         return CHR_DATA;
      end
      if (c == 8'h00) return CHR_END;
      if (c == " " || (c >= 8'h09 && c <= 8'h0D)) return CHR_SPACE;
      if (c == "=") return CHR_PAD;
      return CHR_BAD;
   endfunction

   function automatic void push_word(input logic [7:0] b, input logic fin, input logic ok);
      out_word_type w;
      w.data_byte  = b;
      w.is_final   = fin;
      w.status_ok  = ok;
      w.byte_count = byte_total;
      expected_words.push_back(w);
   endfunction

   // status word, then a fresh string; an error not on the terminator drops the rest
   function automatic void end_string(input logic ok, input logic keep_dropping);
      push_word(8'h00, 1'b1, ok);
      group_pos  = 2'd0;
      pad_state  = PAD_NONE;
      residue    = 8'h00;
      byte_total = 16'd0;
      dropping   = keep_dropping;
   endfunction

   function automatic void decode_char(input logic [7:0] c);
      chr_kind_type kind;
      logic [5:0]   six;
      logic [15:0]  limit;
      logic [16:0]  need;
      logic [7:0]   b;
      kind = kind_of(c, six);
      if (dropping) begin
         if (kind == CHR_END) dropping = 1'b0;
         return;
      end
      if (kind == CHR_SPACE) return;
      if (pad_state == PAD_ONE) begin
         if (kind == CHR_PAD) pad_state = PAD_DONE;
         else end_string(1'b0, kind != CHR_END);
         return;
      end
      if (pad_state == PAD_DONE) begin
         if (kind != CHR_END) end_string(1'b0, 1'b1);
         else end_string(count_mode || residue == 8'h00, 1'b0);
         return;
      end
      case (kind)
         CHR_END: begin
            end_string(group_pos == 2'd0, 1'b0);
            return;
         end
         CHR_BAD: begin
            end_string(1'b0, 1'b1);
            return;
         end
         CHR_PAD: begin
            if (group_pos == 2'd2) pad_state = PAD_ONE;
            else if (group_pos == 2'd3) pad_state = PAD_DONE;
            else end_string(1'b0, 1'b1);
            return;
         end
         default: ;
      endcase

      if (count_mode) begin
         if (group_pos != 2'd0 && byte_total >= MAX_OUTPUT_BYTES) begin
            end_string(1'b0, 1'b1);
            return;
         end
      end else begin
         limit = (capacity < MAX_OUTPUT_BYTES) ? capacity : MAX_OUTPUT_BYTES;
         // middle positions reserve room for the byte after this one
         need = {1'b0, byte_total} + ((group_pos == 2'd1 || group_pos == 2'd2) ? 17'd1 : 17'd0);
         if (need >= {1'b0, limit}) begin
            end_string(1'b0, 1'b1);
            return;
         end
      end

      case (group_pos)
         2'd0: begin
            residue   = {six, 2'b00};
            group_pos = 2'd1;
            return;
         end
         2'd1: begin
            b       = residue | {6'd0, six[5:4]};
            residue = {six[3:0], 4'd0};
         end
         2'd2: begin
            b       = residue | {4'd0, six[5:2]};
            residue = {six[1:0], 6'd0};
         end
         default: begin
            b       = residue | {2'd0, six};
            residue = 8'h00;
         end
      endcase
      group_pos  = group_pos + 2'd1;
      byte_total = byte_total + 16'd1;
      push_word(b, 1'b0, 1'b0);
   endfunction

   always @(posedge clock) begin
      out_word_type got;
      out_word_type want;
      if (reset) begin
         expected_words.delete();
         capacity   = OUT_CAPACITY_RESET;
         count_mode = 1'b0;
         group_pos  = 2'd0;
         pad_state  = PAD_NONE;
         residue    = 8'h00;
         byte_total = 16'd0;
         dropping   = 1'b0;
      end else begin
         // a word leaving now was caused by an earlier character
         if (rsp_valid && rsp_ready) begin
            got.data_byte  = rsp_data_byte;
            got.is_final   = rsp_is_final;
            got.status_ok  = rsp_status_ok;
            got.byte_count = rsp_byte_count;
            if (expected_words.size() == 0) begin
               report($sformatf("unexpected word byte 0x%0h final %0b ok %0b count %0d",
                  got.data_byte, got.is_final, got.status_ok, got.byte_count));
            end else begin
               want = expected_words.pop_front();
               if (got.data_byte !== want.data_byte)
                  report($sformatf("data_byte 0x%0h, expected 0x%0h",
                     got.data_byte, want.data_byte));
               if (got.is_final !== want.is_final)
                  report($sformatf("is_final %0b, expected %0b", got.is_final, want.is_final));
               if (got.status_ok !== want.status_ok)
                  report($sformatf("status_ok %0b, expected %0b",
                     got.status_ok, want.status_ok));
               if (got.byte_count !== want.byte_count)
                  report($sformatf("byte_count %0d, expected %0d",
                     got.byte_count, want.byte_count));
            end
         end
         if (req_valid && req_ready) decode_char(req_char_code);
         if (csr_we) begin
            if (csr_index == CSR_OUT_CAPACITY) capacity = csr_wdata;
            else if (csr_index == CSR_COUNT_ONLY) count_mode = csr_wdata[0];
         end
      end
      words_pending  <= expected_words.size();
      mismatch_count <= errors;
   end

endmodule

[verif/tb_top.sv]
// testbench top for the base64 stream decoder: clock, reset, stimulus and verdict
module tb_top;
   import b64d_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int RESET_CYCLES = 9;
   localparam int HOLD_CYCLES  = 60;
   localparam int SETTLE_CYCLES = 4;
   localparam int ITEM_TARGET  = 700;
   localparam int RUN_LIMIT    = 8_000_000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic [7:0]                 req_char_code = 8'h00;
   logic                       rsp_ready = 1'b0;
   logic                       csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_OUT_CAPACITY;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   logic                       req_ready;
   logic                       rsp_valid;
   logic [7:0]                 rsp_data_byte;
   logic                       rsp_is_final;
   logic                       rsp_status_ok;
   logic [15:0]                rsp_byte_count;

   logic hold_toggle = 1'b0;
   int   send_idle_pct = 0;
   int   take_idle_pct = 0;
   int   chars_sent = 0;
   int   mismatch_count;
   int   words_pending;

   always #(HALF_PERIOD) clock = ~clock;

   base64_stream_decoder_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_is_final   (rsp_is_final),
      .rsp_status_ok  (rsp_status_ok),
      .rsp_byte_count (rsp_byte_count),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   b64d_stream_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_char_code  (req_char_code),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_is_final   (rsp_is_final),
      .rsp_status_ok  (rsp_status_ok),
      .rsp_byte_count (rsp_byte_count),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   // receiver: random stalls, plus a long hold-off whenever hold_toggle flips
   initial begin
      logic seen_hold;
      seen_hold = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_toggle != seen_hold) begin
            seen_hold = hold_toggle;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   initial begin
      #(RUN_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [7:0] sextet_char(input logic [5:0] v);
      if (v < 6'd26) return "A" + v;
      if (v < 6'd52) return "a" + (v - 6'd26);
      if (v < 6'd62) return "0" + (v - 6'd52);
      return (v == 6'd62) ? "+" : "/";
   endfunction

   function automatic logic [7:0] blank_char();
      int k;
      k = $urandom_range(5);
      return (k == 5) ? 8'h20 : 8'(8'h09 + k);
   endfunction

   // valid is only lowered when an idle gap follows, never in the step it is raised
   task automatic send_char(input logic [7:0] c);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   // stop offering and wait until every predicted word has come out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic [15:0] cap, input logic only);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_OUT_CAPACITY;
      csr_wdata <= cap;
      @(posedge clock);
      csr_index <= CSR_COUNT_ONLY;
      csr_wdata <= {15'd0, only};
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // mostly well-formed strings with random content, some flawed, some pure noise
   task automatic send_random_string();
      logic [7:0] text[$];
      logic [5:0] six;
      int n_data;
      int shape;
      int flaw;
      n_data = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
      shape  = $urandom_range(99);
      if (shape >= 80) begin
         repeat (n_data) text.push_back(8'($urandom_range(255)));
      end else begin
         flaw = (shape >= 65) ? $urandom_range(1, 4) : 0;
         if (n_data % 4 == 1) n_data++;
         for (int i = 0; i < n_data; i++) begin
            if ($urandom_range(9) == 0) text.push_back(blank_char());
            six = 6'($urandom);
            // usually keep the bits dropped by the padding at zero
            if (i == n_data - 1 && n_data % 4 != 0 && $urandom_range(4) != 0)
               six = six & ((n_data % 4 == 2) ? 6'h30 : 6'h3C);
            text.push_back(sextet_char(six));
         end
         if (flaw != 2) begin
            if (n_data % 4 == 2) begin
               text.push_back("=");
               if ($urandom_range(3) == 0) text.push_back(blank_char());
               text.push_back("=");
            end else if (n_data % 4 == 3) begin
               text.push_back("=");
            end
         end
         if ($urandom_range(4) == 0) text.push_back(blank_char());
         case (flaw)
            1: if (text.size() != 0)
                  text[$urandom_range(text.size() - 1)] = 8'($urandom_range(1, 255));
            3: text.push_back(sextet_char(6'($urandom)));
            4: text.insert($urandom_range(text.size()), "=");
            default: ;
         endcase
      end
      text.push_back(8'h00);
      foreach (text[i]) send_char(text[i]);
   endtask

   initial begin
      logic [15:0] cap;
      logic        only;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 36;
      take_idle_pct = 74;
      // the top sextet values 63, 63, 62 and 61
      send_text("//+9");
      send_char(8'h00);
      // two pads split by whitespace
      send_text("AA\t=");
      send_char(8'h0B);
      send_text("=");
      send_char(8'h00);
      // second pad missing at the terminator
      send_text("TR=");
      send_char(8'h00);
      // invalid byte, then discarded up to the terminator
      send_char(8'hFF);
      send_text("A");
      send_char(8'h00);
      // pad in the first position of a group
      send_text("=");
      send_char(8'h80);
      send_char(8'h00);
      // empty string
      send_char(8'h00);
      // nonzero bits left under the padding
      send_text("TR==");
      send_char(8'h00);

      for (int regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin
               send_idle_pct = 36;
               take_idle_pct = 74;
            end
            1: begin
               send_idle_pct = 74;
               take_idle_pct = 36;
            end
            default: begin
               send_idle_pct = 0;
               take_idle_pct = 0;
            end
         endcase
         for (int step = 0; step < 4; step++) begin
            case (step)
               0: begin
                  cap  = 16'hFFFF;
                  only = 1'b0;
               end
               1: begin
                  cap  = (regime == 0) ? 16'd0 : 16'($urandom_range(1, 24));
                  only = 1'b0;
               end
               2: begin
                  cap  = 16'($urandom_range(65535));
                  only = 1'b1;
               end
               default: begin
                  cap  = 16'($urandom_range(3, 30));
                  only = 1'b0;
               end
            endcase
            set_mode(cap, only);
            if (regime == 0 && step == 0) begin
               // receiver holds off while a long string keeps coming
               hold_toggle <= ~hold_toggle;
               repeat (48) send_char(sextet_char(6'($urandom)));
               send_char(8'h00);
               drain();
            end
            while (chars_sent < (regime * 4 + step + 1) * ITEM_TARGET / 12)
               send_random_string();
         end
      end

      drain();
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
